// File: rtl/bis_pkg.sv
// Shared types and constants for the binary insertion sorter.
package bis_pkg;

	localparam int DATA_W = 32;

	typedef logic signed [DATA_W-1:0] data_t;

	typedef enum logic {
		ST_FILL,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic  ins;
		logic  drain;
		data_t din;
	} cell_ctrl_t;

endpackage

// File: rtl/binary_insertion_sorter_top.sv
// Top level of the binary insertion sorter: cell chain and fill/drain control.
//
// Usage:
//   Input: a transaction is taken at a rising edge with start high and busy
//   low; it carries value (signed 32 bits) and final_item.
//   Each accepted value is inserted, unless the chain is full, into a chain
//   of MAX_ELEMENTS cells kept in ascending order; every cell compares its
//   entry against the broadcast value and either keeps it, shifts in its lower
//   neighbor, or takes the new value. Non-final items give no result; one item
//   per cycle while busy is low. On the final item the set is drained from
//   cell 0: results come one per cycle on sorted_value with strobe high,
//   starting the cycle after the final item is accepted; busy stays high
//   until the last result. final_result marks the greatest value; overflowed
//   is high on all results of a set that lost values because the chain was full.
//   Results cannot be stalled: each is valid for exactly one cycle.
//   Reset empties the chain and clears the overflow flag; no clearing pass.
module binary_insertion_sorter_top #(
	parameter int MAX_ELEMENTS = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic signed [31:0]     value,
	input  logic                   final_item,
	output logic                   strobe,
	output logic signed [31:0]     sorted_value,
	output logic                   final_result,
	output logic                   overflowed
);
	import bis_pkg::*;

	localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

	state_t          state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic            dropped_q;
	logic            accept, full, insert;
	cell_ctrl_t      ctrl;

	logic  [MAX_ELEMENTS-1:0] ge_vec;
	logic  [MAX_ELEMENTS-1:0] valid_vec;
	data_t                    val_vec [MAX_ELEMENTS];

	assign busy   = (state_q == ST_DRAIN);
	assign accept = start && !busy;
	assign full   = (count_q == CNT_W'(MAX_ELEMENTS));
	assign insert = accept && !full;

	assign ctrl.ins   = insert;
	assign ctrl.drain = busy;
	assign ctrl.din   = value;

	genvar i;
	generate
		for (i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
			logic  p_ge, p_valid, n_valid;
			data_t p_value, n_value;
			if (i == 0) begin : g_first
				assign p_ge    = 1'b0;
				assign p_valid = 1'b0;
				assign p_value = '0;
			end else begin : g_mid
				assign p_ge    = ge_vec[i-1];
				assign p_valid = valid_vec[i-1];
				assign p_value = val_vec[i-1];
			end
			if (i == MAX_ELEMENTS - 1) begin : g_last
				assign n_valid = 1'b0;
				assign n_value = '0;
			end else begin : g_inner
				assign n_valid = valid_vec[i+1];
				assign n_value = val_vec[i+1];
			end
			bis_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.prev_ge    (p_ge),
				.prev_value (p_value),
				.prev_valid (p_valid),
				.next_value (n_value),
				.next_valid (n_valid),
				.ge         (ge_vec[i]),
				.value      (val_vec[i]),
				.valid      (valid_vec[i])
			);
		end
	endgenerate

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_FILL: begin
				if (accept && final_item) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (count_q == CNT_W'(1)) state_d = ST_FILL;
			end
			default: state_d = ST_FILL;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_FILL;
			count_q   <= '0;
			dropped_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (busy) begin
				count_q <= count_q - CNT_W'(1);
				if (count_q == CNT_W'(1)) dropped_q <= 1'b0;
			end else if (accept) begin
				if (full) dropped_q <= 1'b1;
				else      count_q   <= count_q + CNT_W'(1);
			end
		end
	end

	assign strobe       = busy;
	assign sorted_value = val_vec[0];
	assign final_result = busy && (count_q == CNT_W'(1));
	assign overflowed   = dropped_q;

`ifndef SYNTHESIS
	a_valid_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(count_q))
		else $error("cell valid bits disagree with fill count");

	a_strobe_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> valid_vec[0])
		else $error("result strobed from an empty cell");

	a_final_ends_drain: assert property (@(posedge clk) disable iff (!arst_n)
		final_result |=> (!busy && count_q == '0 && !dropped_q))
		else $error("drain did not end after final result");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ELEMENTS))
		else $error("fill count beyond capacity");

	a_sorted_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_vec[0] && valid_vec[1]) |-> (val_vec[0] <= val_vec[1]))
		else $error("lowest cells out of order");
`endif

endmodule

// File: rtl/bis_cell.sv
// One storage cell of the sorting chain: compares, takes the new value or shifts.
module bis_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  bis_pkg::cell_ctrl_t ctrl,
	input  logic               prev_ge,
	input  bis_pkg::data_t     prev_value,
	input  logic               prev_valid,
	input  bis_pkg::data_t     next_value,
	input  logic               next_valid,
	output logic               ge,
	output bis_pkg::data_t     value,
	output logic               valid
);
	import bis_pkg::*;

	data_t value_q;
	logic  valid_q;

	// an empty cell counts as greater than any value
	assign ge    = !valid_q || (value_q >= ctrl.din);
	assign value = value_q;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.drain) begin
			valid_q <= next_valid;
		end else if (ctrl.ins && ge) begin
			valid_q <= prev_ge ? prev_valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.drain) begin
			value_q <= next_value;
		end else if (ctrl.ins && ge) begin
			value_q <= prev_ge ? prev_value : ctrl.din;
		end
	end

endmodule
